// ===== sv/bfv_pkg.sv =====
package bfv_pkg;

   // Frame framing bytes and sizes
   localparam logic [7:0] FRAME_START    = 8'hDD;
   localparam logic [7:0] FRAME_STOP     = 8'h77;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd7;
   localparam logic [8:0] COUNT_MAX      = 9'd263;

   // Fixed frame positions, and positions relative to the declared length
   localparam logic [8:0] POS_START    = 9'd0;
   localparam logic [8:0] POS_REGISTER = 9'd1;
   localparam logic [8:0] POS_STATUS   = 9'd2;
   localparam logic [8:0] POS_LENGTH   = 9'd3;
   localparam logic [9:0] OFS_CHECK_HI = 10'd4;
   localparam logic [9:0] OFS_CHECK_LO = 10'd5;
   localparam logic [9:0] OFS_STOP     = 10'd6;

   // Verdict codes
   typedef enum logic [2:0] {
      RESULT_OK         = 3'd0,
      RESULT_SHORT      = 3'd1,
      RESULT_BAD_START  = 3'd2,
      RESULT_BAD_LENGTH = 3'd3,
      RESULT_BAD_CHECK  = 3'd4,
      RESULT_BAD_STOP   = 3'd5
   } result_code_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [2:0] result_code;
      logic [7:0] register_id;
      logic [7:0] status_value;
      logic [7:0] payload_length;
   } rsp_type;

endpackage

// ===== sv/bms_frame_verifier.sv =====
// Battery-monitor reply frame checker. Feed the received buffer one byte per
// transaction, with end_of_buffer set on the last byte; that byte yields one
// verdict (ok, short, bad start, length mismatch, checksum mismatch, bad stop)
// plus the register, status and length bytes, and the block then starts over
// for the next buffer. A byte is taken every cycle while the input does not
// stall. The final byte goes through the input register, then the position
// tracker's add and compare, then the result register, which drives rsp_valid.
// The input side keeps accepting while a verdict waits in the result register,
// and stalls only when a second final byte would need that register.
module bms_frame_verifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bfv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bfv_pkg::rsp_type rsp_data
);

   logic             s1_valid_ff, s1_valid_in;
   bfv_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   bfv_pkg::rsp_type rsp_data_ff;
   bfv_pkg::rsp_type verdict;
   logic             out_free;
   logic             s1_advance;

   // Flow control: non-final bytes never need the result register
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && (!s1_data_ff.end_of_buffer || out_free);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 :
                        (s1_advance ? 1'b0 : s1_valid_ff);

   bfv_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .take    (s1_advance),
      .byte_in (s1_data_ff),
      .verdict (verdict)
   );

   // Result register
   always_comb begin
      if (s1_advance && s1_data_ff.end_of_buffer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance && s1_data_ff.end_of_buffer) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/bfv_tracker.sv =====
module bfv_tracker (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  bfv_pkg::req_type byte_in,
   output bfv_pkg::rsp_type verdict
);

   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  declared_length_ff, declared_length_in;
   logic [15:0] sum_accum_ff, sum_accum_in;
   logic [15:0] received_check_ff, received_check_in;
   logic        start_good_ff, start_good_in;
   logic [7:0]  stop_value_ff, stop_value_in;
   logic [7:0]  reg_held_ff, reg_held_in;
   logic [7:0]  status_held_ff, status_held_in;

   logic [9:0]  pos_wide;
   logic [9:0]  len_wide;
   logic [15:0] sum_added;
   logic [15:0] expect_check;
   logic [8:0]  data_count;
   bfv_pkg::result_code_type code;

   assign pos_wide  = {1'b0, byte_count_ff};
   assign len_wide  = {2'b00, declared_length_ff};
   assign sum_added = sum_accum_ff + {8'h00, byte_in.rx_byte};

   // Field capture by frame position
   always_comb begin
      declared_length_in = declared_length_ff;
      sum_accum_in       = sum_accum_ff;
      received_check_in  = received_check_ff;
      start_good_in      = start_good_ff;
      stop_value_in      = stop_value_ff;
      reg_held_in        = reg_held_ff;
      status_held_in     = status_held_ff;
      if (byte_count_ff == bfv_pkg::POS_START) begin
         start_good_in = (byte_in.rx_byte == bfv_pkg::FRAME_START);
      end else if (byte_count_ff == bfv_pkg::POS_REGISTER) begin
         reg_held_in = byte_in.rx_byte;
      end else if (byte_count_ff == bfv_pkg::POS_STATUS) begin
         status_held_in = byte_in.rx_byte;
         sum_accum_in   = sum_added;
      end else if (byte_count_ff == bfv_pkg::POS_LENGTH) begin
         declared_length_in = byte_in.rx_byte;
         sum_accum_in       = sum_added;
      end else if (pos_wide < len_wide + bfv_pkg::OFS_CHECK_HI) begin
         sum_accum_in = sum_added;
      end else if (pos_wide == len_wide + bfv_pkg::OFS_CHECK_HI) begin
         received_check_in = {byte_in.rx_byte, received_check_ff[7:0]};
      end else if (pos_wide == len_wide + bfv_pkg::OFS_CHECK_LO) begin
         received_check_in = {received_check_ff[15:8], byte_in.rx_byte};
      end else if (pos_wide == len_wide + bfv_pkg::OFS_STOP) begin
         stop_value_in = byte_in.rx_byte;
      end
   end

   // Saturating byte count
   assign byte_count_in = (byte_count_ff < bfv_pkg::COUNT_MAX) ?
                          byte_count_ff + 9'd1 : byte_count_ff;

   // Verdict from the state as it stands after this byte
   assign expect_check = 16'h0000 - sum_accum_in;
   assign data_count   = byte_count_in - bfv_pkg::FRAME_OVERHEAD;

   always_comb begin
      if (byte_count_in < bfv_pkg::FRAME_OVERHEAD) begin
         code = bfv_pkg::RESULT_SHORT;
      end else if (!start_good_in) begin
         code = bfv_pkg::RESULT_BAD_START;
      end else if ({1'b0, declared_length_in} != data_count) begin
         code = bfv_pkg::RESULT_BAD_LENGTH;
      end else if (expect_check != received_check_in) begin
         code = bfv_pkg::RESULT_BAD_CHECK;
      end else if (stop_value_in != bfv_pkg::FRAME_STOP) begin
         code = bfv_pkg::RESULT_BAD_STOP;
      end else begin
         code = bfv_pkg::RESULT_OK;
      end
   end

   assign verdict.result_code    = code;
   assign verdict.register_id    = reg_held_in;
   assign verdict.status_value   = status_held_in;
   assign verdict.payload_length = declared_length_in;

   // State update; the final byte of a buffer clears everything
   always_ff @(posedge clock) begin
      if (reset || (take && byte_in.end_of_buffer)) begin
         byte_count_ff      <= '0;
         declared_length_ff <= '0;
         sum_accum_ff       <= '0;
         received_check_ff  <= '0;
         start_good_ff      <= 1'b0;
         stop_value_ff      <= '0;
         reg_held_ff        <= '0;
         status_held_ff     <= '0;
      end else if (take) begin
         byte_count_ff      <= byte_count_in;
         declared_length_ff <= declared_length_in;
         sum_accum_ff       <= sum_accum_in;
         received_check_ff  <= received_check_in;
         start_good_ff      <= start_good_in;
         stop_value_ff      <= stop_value_in;
         reg_held_ff        <= reg_held_in;
         status_held_ff     <= status_held_in;
      end
   end

endmodule
